// File: design/glyph_quad_text_layout_macros.svh
// Assertion macros for the checker file of the text layout block.
// Each macro expects a signal named clock in the enclosing scope, and GQTL_ASSERT also expects reset.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_MACROS_SVH

// Property checked outside reset.
`define GQTL_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("gqtl check failed");

// Property checked at every edge, reset included.
`define GQTL_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("gqtl check failed");

`endif

// File: design/gqtl_pkg.sv
`default_nettype none

package gqtl_pkg;

   localparam int GLYPH_COUNT = 256;
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
   localparam int CODE_W      = 8;
   localparam int CODE_EXT_W  = CODE_W + 1;

   localparam int POS_W      = 24;
   localparam int TEX_W      = 16;
   localparam int PIX_W      = 12;
   localparam int SCALE_W    = 16;
   localparam int LINE_W     = 12;
   localparam int SUM_W      = 32;
   localparam int OFF_SC_W   = PIX_W + SCALE_W + 1;
   localparam int DIM_SC_W   = PIX_W + SCALE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int VERT_CNT_W = 3;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_CHAR = 1'b1;

   localparam logic [CODE_W-1:0] CHAR_LF = 8'd10;
   localparam logic [CODE_W-1:0] CHAR_CR = 8'd13;

   localparam logic STATUS_VERTEX = 1'b0;
   localparam logic STATUS_WARN   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z    = 3'd4;

   localparam logic [SCALE_W-1:0] SCALE_RESET       = 16'd256;
   localparam logic [LINE_W-1:0]  LINE_HEIGHT_RESET = 12'd5;

   // Vertex order of a quad: which corner each of the six vertices takes.
   localparam logic [VERT_CNT_W-1:0] VERT_LAST = 3'd5;
   localparam logic [5:0] USE_X1_MASK = 6'b101100;
   localparam logic [5:0] USE_Y1_MASK = 6'b110010;

   localparam logic signed [SUM_W-1:0] SUM_POS_MAX = SUM_W'(2 ** (POS_W - 1) - 1);
   localparam logic signed [SUM_W-1:0] SUM_POS_MIN = SUM_W'(-(2 ** (POS_W - 1)));

   typedef struct packed {
      logic [TEX_W-1:0] u0;
      logic [TEX_W-1:0] v0;
      logic [TEX_W-1:0] u1;
      logic [TEX_W-1:0] v1;
   } glyph_coords_type;

   typedef struct packed {
      logic [PIX_W-1:0]        width;
      logic [PIX_W-1:0]        height;
      logic signed [PIX_W-1:0] offset_x;
      logic signed [PIX_W-1:0] offset_y;
      logic [PIX_W-1:0]        advance_x;
   } glyph_metrics_type;

   localparam int COORDS_W  = $bits(glyph_coords_type);
   localparam int METRICS_W = $bits(glyph_metrics_type);

   typedef struct packed {
      glyph_coords_type  coords;
      glyph_metrics_type metrics;
      logic              valid;
   } glyph_read_type;

   typedef struct packed {
      logic first;
      logic newline;
      logic in_range;
   } char_req_type;

   typedef struct packed {
      logic [SCALE_W-1:0]      scale;
      logic [LINE_W-1:0]       line_height;
      logic signed [POS_W-1:0] origin_x;
      logic signed [POS_W-1:0] origin_y;
      logic signed [POS_W-1:0] origin_z;
   } layout_cfg_type;

   typedef struct packed {
      logic                    warn;
      logic signed [POS_W-1:0] x0;
      logic signed [POS_W-1:0] x1;
      logic signed [POS_W-1:0] y0;
      logic signed [POS_W-1:0] y1;
      glyph_coords_type        coords;
   } quad_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > SUM_POS_MAX) begin
         r = POS_W'(SUM_POS_MAX);
      end else if (v < SUM_POS_MIN) begin
         r = POS_W'(SUM_POS_MIN);
      end else begin
         r = POS_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/gqtl_ram.sv
`default_nettype none

module gqtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/gqtl_table.sv
`default_nettype none

module gqtl_table
   import gqtl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [GLYPH_IDX_W-1:0] wr_addr,
   input  wire glyph_coords_type       wr_coords,
   input  wire glyph_metrics_type      wr_metrics,
   input  wire logic                   rd_en,
   input  wire logic [GLYPH_IDX_W-1:0] rd_addr,
   output glyph_read_type              rd_glyph
);

   logic [GLYPH_COUNT-1:0] valid_ff;
   logic [GLYPH_COUNT-1:0] valid_in;
   logic                   rd_valid_ff;
   logic [COORDS_W-1:0]    coords_q;
   logic [METRICS_W-1:0]   metrics_q;

   gqtl_ram #(.WIDTH(COORDS_W), .DEPTH(GLYPH_COUNT)) u_coords_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_coords),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (coords_q)
   );

   gqtl_ram #(.WIDTH(METRICS_W), .DEPTH(GLYPH_COUNT)) u_metrics_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_metrics),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (metrics_q)
   );

   // Valid marks live in flops so that reset can clear every entry at once.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_glyph.coords  = glyph_coords_type'(coords_q);
   assign rd_glyph.metrics = glyph_metrics_type'(metrics_q);
   assign rd_glyph.valid   = rd_valid_ff;

endmodule

`default_nettype wire

// File: design/gqtl_geom.sv
`default_nettype none

module gqtl_geom
   import gqtl_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire layout_cfg_type cfg,
   input  wire logic           in_valid,
   input  wire char_req_type   in_req,
   output logic                in_ready,
   input  wire glyph_read_type rd_glyph,
   output logic                quad_valid,
   output quad_type            quad,
   input  wire logic           quad_ready
);

   // Stage 1: glyph entry arrives from the table.
   logic         s1_valid_ff, s1_valid_in;
   char_req_type s1_req_ff;
   logic         s1_go, s1_glyph, s1_warn;

   // Stage 2: scaled pixel quantities.
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_first_ff, s2_nl_ff, s2_warn_ff;
   logic signed [OFF_SC_W-1:0] s2_offx_sc_ff, s2_offy_sc_ff;
   logic [DIM_SC_W-1:0]        s2_w_sc_ff, s2_h_sc_ff, s2_adv_sc_ff, s2_lh_sc_ff;
   glyph_coords_type           s2_coords_ff;
   logic signed [SUM_W-1:0]    s2_bx, s2_by;
   logic signed [POS_W-1:0]    s2_px, s2_py;
   logic                       s2_go;
   logic signed [SCALE_W:0]    scale_s;

   // Stage 3: quad corners before clamping.
   logic                    s3_valid_ff, s3_valid_in;
   logic                    s3_warn_ff;
   logic signed [SUM_W-1:0] s3_bx_ff, s3_by_ff;
   logic [DIM_SC_W-1:0]     s3_w_sc_ff, s3_h_sc_ff;
   glyph_coords_type        s3_coords_ff;
   logic                    s3_go;

   logic signed [POS_W-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;

   assign s3_go    = s3_valid_ff && quad_ready;
   assign s2_go    = s2_valid_ff && (s2_nl_ff || !s3_valid_ff || s3_go);
   assign s1_go    = s1_valid_ff && (!s2_valid_ff || s2_go);
   assign in_ready = !s1_valid_ff || s1_go;

   assign s1_glyph = !s1_req_ff.newline && s1_req_ff.in_range && rd_glyph.valid;
   assign s1_warn  = !s1_req_ff.newline && !s1_glyph;
   assign scale_s  = signed'({1'b0, cfg.scale});

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (in_valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_go) begin
         s2_valid_in = 1'b1;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
      s3_valid_in = s3_valid_ff;
      if (s2_go && !s2_nl_ff) begin
         s3_valid_in = 1'b1;
      end else if (s3_go) begin
         s3_valid_in = 1'b0;
      end
   end

   // The pen is cleared ahead of the character when the item starts a new text.
   assign s2_px = s2_first_ff ? '0 : pen_x_ff;
   assign s2_py = s2_first_ff ? '0 : pen_y_ff;
   assign s2_bx = SUM_W'(cfg.origin_x) + SUM_W'(s2_px) + SUM_W'(s2_offx_sc_ff);
   assign s2_by = SUM_W'(cfg.origin_y) + SUM_W'(s2_py) + SUM_W'(s2_offy_sc_ff);

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      if (s2_go) begin
         if (s2_nl_ff) begin
            pen_x_in = '0;
            pen_y_in = sat_pos(SUM_W'(s2_py) + signed'(SUM_W'(s2_lh_sc_ff)));
         end else if (s2_warn_ff) begin
            pen_x_in = s2_px;
            pen_y_in = s2_py;
         end else begin
            pen_x_in = sat_pos(SUM_W'(s2_px) + signed'(SUM_W'(s2_adv_sc_ff)));
            pen_y_in = s2_py;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         pen_x_ff    <= '0;
         pen_y_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         pen_x_ff    <= pen_x_in;
         pen_y_ff    <= pen_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_req_ff <= in_req;
      end
      if (s1_go) begin
         s2_first_ff   <= s1_req_ff.first;
         s2_nl_ff      <= s1_req_ff.newline;
         s2_warn_ff    <= s1_warn;
         s2_offx_sc_ff <= OFF_SC_W'(rd_glyph.metrics.offset_x) * OFF_SC_W'(scale_s);
         s2_offy_sc_ff <= OFF_SC_W'(rd_glyph.metrics.offset_y) * OFF_SC_W'(scale_s);
         s2_w_sc_ff    <= DIM_SC_W'(rd_glyph.metrics.width) * DIM_SC_W'(cfg.scale);
         s2_h_sc_ff    <= DIM_SC_W'(rd_glyph.metrics.height) * DIM_SC_W'(cfg.scale);
         s2_adv_sc_ff  <= DIM_SC_W'(rd_glyph.metrics.advance_x) * DIM_SC_W'(cfg.scale);
         s2_lh_sc_ff   <= DIM_SC_W'(cfg.line_height) * DIM_SC_W'(cfg.scale);
         s2_coords_ff  <= rd_glyph.coords;
      end
      if (s2_go && !s2_nl_ff) begin
         s3_warn_ff   <= s2_warn_ff;
         s3_bx_ff     <= s2_bx;
         s3_by_ff     <= s2_by;
         s3_w_sc_ff   <= s2_w_sc_ff;
         s3_h_sc_ff   <= s2_h_sc_ff;
         s3_coords_ff <= s2_coords_ff;
      end
   end

   assign quad_valid  = s3_valid_ff;
   assign quad.warn   = s3_warn_ff;
   assign quad.x0     = sat_pos(s3_bx_ff);
   assign quad.x1     = sat_pos(s3_bx_ff + signed'(SUM_W'(s3_w_sc_ff)));
   assign quad.y0     = sat_pos(s3_by_ff);
   assign quad.y1     = sat_pos(s3_by_ff + signed'(SUM_W'(s3_h_sc_ff)));
   assign quad.coords = s3_coords_ff;

endmodule

`default_nettype wire

// File: design/gqtl_emit.sv
`default_nettype none

module gqtl_emit
   import gqtl_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic signed [POS_W-1:0] origin_z,
   input  wire logic                    quad_valid,
   input  wire quad_type                quad,
   output logic                         quad_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [POS_W-1:0]      rsp_vert_x,
   output logic signed [POS_W-1:0]      rsp_vert_y,
   output logic signed [POS_W-1:0]      rsp_vert_z,
   output logic [TEX_W-1:0]             rsp_tex_u,
   output logic [TEX_W-1:0]             rsp_tex_v,
   output logic                         rsp_status,
   output logic                         rsp_last_of_run
);

   logic                  e_valid_ff, e_valid_in;
   logic [VERT_CNT_W-1:0] e_cnt_ff, e_cnt_in;
   quad_type              e_quad_ff;
   logic                  e_fire, e_last, e_load, use_x1, use_y1;

   logic                    o_valid_ff, o_valid_in;
   logic signed [POS_W-1:0] o_x_ff, o_y_ff, o_z_ff;
   logic [TEX_W-1:0]        o_u_ff, o_v_ff;
   logic                    o_status_ff, o_last_ff;

   assign e_fire     = e_valid_ff && (!o_valid_ff || rsp_ready);
   assign e_last     = e_quad_ff.warn || (e_cnt_ff == VERT_LAST);
   assign quad_ready = !e_valid_ff || (e_fire && e_last);
   assign e_load     = quad_valid && quad_ready;
   assign use_x1     = USE_X1_MASK[e_cnt_ff];
   assign use_y1     = USE_Y1_MASK[e_cnt_ff];

   always_comb begin
      e_valid_in = e_valid_ff;
      e_cnt_in   = e_cnt_ff;
      if (e_load) begin
         e_valid_in = 1'b1;
         e_cnt_in   = '0;
      end else if (e_fire) begin
         e_valid_in = !e_last;
         e_cnt_in   = e_cnt_ff + 1'b1;
      end
      o_valid_in = o_valid_ff;
      if (e_fire) begin
         o_valid_in = 1'b1;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         e_cnt_ff   <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
         e_cnt_ff   <= e_cnt_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_load) begin
         e_quad_ff <= quad;
      end
      if (e_fire) begin
         o_last_ff <= e_last;
         if (e_quad_ff.warn) begin
            o_x_ff      <= '0;
            o_y_ff      <= '0;
            o_z_ff      <= '0;
            o_u_ff      <= '0;
            o_v_ff      <= '0;
            o_status_ff <= STATUS_WARN;
         end else begin
            o_x_ff      <= use_x1 ? e_quad_ff.x1 : e_quad_ff.x0;
            o_y_ff      <= use_y1 ? e_quad_ff.y1 : e_quad_ff.y0;
            o_z_ff      <= origin_z;
            o_u_ff      <= use_x1 ? e_quad_ff.coords.u1 : e_quad_ff.coords.u0;
            o_v_ff      <= use_y1 ? e_quad_ff.coords.v1 : e_quad_ff.coords.v0;
            o_status_ff <= STATUS_VERTEX;
         end
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_vert_x      = o_x_ff;
   assign rsp_vert_y      = o_y_ff;
   assign rsp_vert_z      = o_z_ff;
   assign rsp_tex_u       = o_u_ff;
   assign rsp_tex_v       = o_v_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_last_of_run = o_last_ff;

endmodule

`default_nettype wire

// File: design/glyph_quad_text_layout.sv
// Bitmap-font text layout. The req channel carries one item per transfer:
// a load item (mode 0) writes a glyph entry into the table, a character item
// (mode 1) lays out one character at the pen. The rsp channel carries one
// result per transfer: six vertices, two triangles, for a glyph that has
// been loaded, or one warning result for a code with no entry. Line feed and
// carriage return move the pen and give no result. The csr port writes the
// scale, line height and origin registers; the user must write them only
// while the block is idle, which the block itself does not enforce.
// A character item reads the glyph table when accepted; its first vertex
// passes the geometry stages, the emitter quad and the output registers.
// A load item writes the table at its transfer; loads and newlines take no
// result slot. The emitter walks the six vertices of each loaded glyph's
// quad and sets the character rate; warnings go one per cycle if rsp_ready
// is high. Reset clears the pen, the pipeline, every valid mark of the glyph
// table and restores the register defaults; glyph data stays as it was. While
// rsp_ready is low the result holds in the output register, the pipeline
// behind it fills, and req_ready falls once all stages are occupied.
`default_nettype none

module glyph_quad_text_layout
   import gqtl_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_mode,
   input  wire logic [CODE_W-1:0]       req_char_code,
   input  wire logic                    req_first_char,
   input  wire logic [TEX_W-1:0]        req_tex_u0,
   input  wire logic [TEX_W-1:0]        req_tex_v0,
   input  wire logic [TEX_W-1:0]        req_tex_u1,
   input  wire logic [TEX_W-1:0]        req_tex_v1,
   input  wire logic [PIX_W-1:0]        req_glyph_width,
   input  wire logic [PIX_W-1:0]        req_glyph_height,
   input  wire logic signed [PIX_W-1:0] req_offset_x,
   input  wire logic signed [PIX_W-1:0] req_offset_y,
   input  wire logic [PIX_W-1:0]        req_advance_x,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [POS_W-1:0]      rsp_vert_x,
   output logic signed [POS_W-1:0]      rsp_vert_y,
   output logic signed [POS_W-1:0]      rsp_vert_z,
   output logic [TEX_W-1:0]             rsp_tex_u,
   output logic [TEX_W-1:0]             rsp_tex_v,
   output logic                         rsp_status,
   output logic                         rsp_last_of_run,
   input  wire logic                    csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   layout_cfg_type    cfg_ff, cfg_in;
   logic              req_fire, code_in_range, load_we, char_go;
   char_req_type      char_req;
   glyph_coords_type  wr_coords;
   glyph_metrics_type wr_metrics;
   glyph_read_type    rd_glyph;
   logic              quad_valid, quad_ready;
   quad_type          quad;

   // Register writes; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SCALE:       cfg_in.scale       = csr_wdata[SCALE_W-1:0];
            CSR_LINE_HEIGHT: cfg_in.line_height = csr_wdata[LINE_W-1:0];
            CSR_ORIGIN_X:    cfg_in.origin_x    = signed'(csr_wdata[POS_W-1:0]);
            CSR_ORIGIN_Y:    cfg_in.origin_y    = signed'(csr_wdata[POS_W-1:0]);
            CSR_ORIGIN_Z:    cfg_in.origin_z    = signed'(csr_wdata[POS_W-1:0]);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale       <= SCALE_RESET;
         cfg_ff.line_height <= LINE_HEIGHT_RESET;
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.origin_z    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Codes past the table are never written and always read as missing.
   assign req_fire      = req_valid && req_ready;
   assign code_in_range = CODE_EXT_W'(req_char_code) < CODE_EXT_W'(GLYPH_COUNT);
   assign load_we       = req_fire && (req_mode == MODE_LOAD) && code_in_range;
   assign char_go       = req_fire && (req_mode == MODE_CHAR);

   assign char_req.first    = req_first_char;
   assign char_req.newline  = (req_char_code == CHAR_LF) || (req_char_code == CHAR_CR);
   assign char_req.in_range = code_in_range;

   assign wr_coords.u0 = req_tex_u0;
   assign wr_coords.v0 = req_tex_v0;
   assign wr_coords.u1 = req_tex_u1;
   assign wr_coords.v1 = req_tex_v1;

   assign wr_metrics.width     = req_glyph_width;
   assign wr_metrics.height    = req_glyph_height;
   assign wr_metrics.offset_x  = req_offset_x;
   assign wr_metrics.offset_y  = req_offset_y;
   assign wr_metrics.advance_x = req_advance_x;

   // A load and a read of the same entry never fall in the same cycle,
   // since one item is taken per transfer and the read is issued at transfer.
   gqtl_table u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (load_we),
      .wr_addr    (req_char_code[GLYPH_IDX_W-1:0]),
      .wr_coords  (wr_coords),
      .wr_metrics (wr_metrics),
      .rd_en      (char_go),
      .rd_addr    (req_char_code[GLYPH_IDX_W-1:0]),
      .rd_glyph   (rd_glyph)
   );

   gqtl_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (char_go),
      .in_req     (char_req),
      .in_ready   (req_ready),
      .rd_glyph   (rd_glyph),
      .quad_valid (quad_valid),
      .quad       (quad),
      .quad_ready (quad_ready)
   );

   gqtl_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .origin_z        (cfg_ff.origin_z),
      .quad_valid      (quad_valid),
      .quad            (quad),
      .quad_ready      (quad_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_vert_z      (rsp_vert_z),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: design/gqtl_checker.sv
`default_nettype none
`include "glyph_quad_text_layout_macros.svh"

module gqtl_checker
   import gqtl_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    req_mode,
   input wire logic [CODE_W-1:0]       req_char_code,
   input wire logic                    req_first_char,
   input wire logic [TEX_W-1:0]        req_tex_u0,
   input wire logic [TEX_W-1:0]        req_tex_v0,
   input wire logic [TEX_W-1:0]        req_tex_u1,
   input wire logic [TEX_W-1:0]        req_tex_v1,
   input wire logic [PIX_W-1:0]        req_glyph_width,
   input wire logic [PIX_W-1:0]        req_glyph_height,
   input wire logic signed [PIX_W-1:0] req_offset_x,
   input wire logic signed [PIX_W-1:0] req_offset_y,
   input wire logic [PIX_W-1:0]        req_advance_x,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [POS_W-1:0] rsp_vert_x,
   input wire logic signed [POS_W-1:0] rsp_vert_y,
   input wire logic signed [POS_W-1:0] rsp_vert_z,
   input wire logic [TEX_W-1:0]        rsp_tex_u,
   input wire logic [TEX_W-1:0]        rsp_tex_v,
   input wire logic                    rsp_status,
   input wire logic                    rsp_last_of_run,
   input wire logic                    csr_write_en,
   input wire logic [CSR_IDX_W-1:0]    csr_index,
   input wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   // A stalled result keeps its x, y, tex_u and last-of-run fields.
   `GQTL_ASSERT(rsp_hold_a, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vert_x) && $stable(rsp_vert_y) && $stable(rsp_tex_u) && $stable(rsp_last_of_run))

   // A warning stands alone and carries zero geometry.
   `GQTL_ASSERT(warn_alone_a, rsp_valid && rsp_status == STATUS_WARN |-> rsp_last_of_run && rsp_vert_x == '0 && rsp_vert_y == '0 && rsp_tex_u == '0 && rsp_tex_v == '0)

   // The vertices of one quad follow each other without a gap.
   `GQTL_ASSERT(quad_burst_a, rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_status == STATUS_VERTEX)

   // Nothing is offered right after reset.
   `GQTL_ASSERT_ALWAYS(reset_quiet_a, reset |=> !rsp_valid)

endmodule

bind glyph_quad_text_layout gqtl_checker u_gqtl_checker (.*);

`default_nettype wire
